[rtl/core/dctig_pkg.sv]
`default_nettype none

package dctig_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_DOS_VERSION = 2'd0;
	localparam cfg_idx_t REG_CAT_TRK     = 2'd1;
	localparam cfg_idx_t REG_USED_CNT    = 2'd2;
	localparam cfg_idx_t REG_VOLUME      = 2'd3;

	localparam int CFG_DATA_W = 10;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Reset values of the registers.
	localparam logic [9:0] RST_DOS_VERSION = 10'd330;
	localparam logic [5:0] RST_CAT_TRK     = 6'd17;
	localparam logic [7:0] RST_USED_CNT    = 8'd0;
	localparam logic [7:0] RST_VOLUME      = 8'd254;

	// Disk geometry.
	localparam logic [9:0] VERSION_16_SECTORS = 10'd330;
	localparam logic [4:0] SECTORS_13         = 5'd13;
	localparam logic [4:0] SECTORS_16         = 5'd16;
	localparam logic [3:0] LAST_SECTOR_13     = 4'd12;
	localparam logic [7:0] TRACK_COUNT        = 8'd35;
	localparam logic [7:0] TS_CAPACITY        = 8'((256 - 'hC) / 2);
	localparam logic [15:0] FREE_MAP_13       = 16'hFFF8;
	localparam logic [15:0] FREE_MAP_16       = 16'hFFFF;

	// Table of contents byte positions.
	localparam logic [7:0] TOC_LINK_TRACK  = 8'h01;
	localparam logic [7:0] TOC_LINK_SECTOR = 8'h02;
	localparam logic [7:0] TOC_VERSION     = 8'h03;
	localparam logic [7:0] TOC_VOLUME      = 8'h06;
	localparam logic [7:0] TOC_TS_CAPACITY = 8'h27;
	localparam logic [7:0] TOC_LAST_TRACK  = 8'h30;
	localparam logic [7:0] TOC_DIRECTION   = 8'h31;
	localparam logic [7:0] TOC_TRACKS      = 8'h34;
	localparam logic [7:0] TOC_SECTORS     = 8'h35;
	localparam logic [7:0] TOC_BYTES_LO    = 8'h36;
	localparam logic [7:0] TOC_BYTES_HI    = 8'h37;
	localparam logic [7:0] MAP_START       = 8'h38;
	localparam logic [7:0] MAP_END         = 8'hC4;

	// Reciprocal of ten for values below 1029: x / 10 == (x * 205) >> 11.
	localparam logic [7:0] RECIP_10 = 8'd205;
	localparam int RECIP_SHIFT = 11;

endpackage

`default_nettype wire

[rtl/core/dos_catalog_track_image_generator_unit.sv]
`default_nettype none

// Catalog track image generator for a freshly formatted DOS 3.x style disk.
// A command transfer is taken on any rising edge with start high and busy low;
// busy is always low, so one byte offset may be issued every cycle. The offset
// selects sector * 256 + byte of a 13 or 16 sector catalog track image.
// After a command transfer, the offset passes the stage 1 and 2 registers,
// then done rises for one cycle with the image byte, an invalid flag for
// offsets past a 13 sector image, and a flag for the final byte of the image.
// Results leave in command order. Throughput is one byte per cycle through
// the three register stages: decode of the offset with the version product,
// the sectors taken by the bitmap track, and the bitmap shift with the byte
// selection into the output registers. The receiver cannot stall the block,
// so the pipeline never holds. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready. The user must write it
// only while no command is in flight, which the block itself does not enforce.
// Reset clears the pipeline valid bits and loads the configuration defaults:
// version 330, catalog track 17, no used sectors and volume 254.
module dos_catalog_track_image_generator_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire  [11:0]            byte_offset,
	output logic                   done,
	output logic [7:0]             data_byte,
	output logic                   offset_invalid,
	output logic                   last_byte,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  dctig_pkg::cfg_idx_t  cfg_index,
	input  wire  dctig_pkg::cfg_data_t cfg_data
);
	import dctig_pkg::*;

	// Configuration registers.
	logic [9:0] dos_version_q;
	logic [5:0] cat_trk_q;
	logic [7:0] used_cnt_q;
	logic [7:0] volume_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dos_version_q <= RST_DOS_VERSION;
			cat_trk_q     <= RST_CAT_TRK;
			used_cnt_q    <= RST_USED_CNT;
			volume_q      <= RST_VOLUME;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DOS_VERSION: dos_version_q <= cfg_data;
				REG_CAT_TRK:     cat_trk_q     <= cfg_data[5:0];
				REG_USED_CNT:    used_cnt_q    <= cfg_data[7:0];
				REG_VOLUME:      volume_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The sector count depends only on the version register.
	logic       spt13;
	logic [4:0] spt;
	assign spt13 = (dos_version_q < VERSION_16_SECTORS);
	assign spt   = spt13 ? SECTORS_13 : SECTORS_16;

	// Stage 1 logic: decode the offset, find the bitmap track and how many
	// ordinary tracks come before it, and start the version digit.
	logic [7:0]  map_rel;
	logic [5:0]  track;
	logic [5:0]  tracks_before;
	logic [17:0] ver_recip;
	logic        invalid_c;
	logic        last_c;

	always_comb begin
		map_rel       = byte_offset[7:0] - MAP_START;
		track         = map_rel[7:2];
		tracks_before = track - ((cat_trk_q < track) ? 6'd1 : 6'd0);
		ver_recip     = 18'(dos_version_q * RECIP_10);
		invalid_c     = spt13 && (byte_offset[11:8] > LAST_SECTOR_13);
		last_c        = (byte_offset[7:0] == 8'hFF)
			&& (spt13 ? (byte_offset[11:8] == LAST_SECTOR_13) : (byte_offset[11:8] == 4'hF));
	end

	logic        vld_s1;
	logic        invalid_s1;
	logic        last_s1;
	logic [3:0]  sec_s1;
	logic [7:0]  byte_s1;
	logic [1:0]  map_lane_s1;
	logic        is_cat_s1;
	logic [5:0]  tracks_before_s1;
	logic [6:0]  ver_tens_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		invalid_s1       <= invalid_c;
		last_s1          <= last_c;
		sec_s1           <= byte_offset[11:8];
		byte_s1          <= byte_offset[7:0];
		map_lane_s1      <= map_rel[1:0];
		is_cat_s1        <= (track == cat_trk_q);
		tracks_before_s1 <= tracks_before;
		ver_tens_s1      <= ver_recip[RECIP_SHIFT +: 7];
	end

	// Stage 2 logic: sectors absorbed by the tracks before this one, the
	// sectors this track takes, and the hundreds of the version.
	logic [9:0]  absorbed;
	logic [10:0] remain;
	logic [4:0]  take;
	logic [14:0] tens_recip;

	always_comb begin
		if (spt13) begin
			absorbed = {1'b0, tracks_before_s1, 3'b000} + {2'b00, tracks_before_s1, 2'b00}
				+ {4'b0000, tracks_before_s1};
		end else begin
			absorbed = {tracks_before_s1, 4'b0000};
		end
		remain = {3'b000, used_cnt_q} - {1'b0, absorbed};
		if (is_cat_s1) begin
			take = spt;
		end else if (remain[10] || (remain == 11'd0)) begin
			take = 5'd0;
		end else if (remain >= {6'd0, spt}) begin
			take = spt;
		end else begin
			take = remain[4:0];
		end
		tens_recip = 15'(ver_tens_s1 * RECIP_10);
	end

	logic        vld_s2;
	logic        invalid_s2;
	logic        last_s2;
	logic [3:0]  sec_s2;
	logic [7:0]  byte_s2;
	logic [1:0]  map_lane_s2;
	logic [4:0]  take_s2;
	logic [6:0]  ver_tens_s2;
	logic [3:0]  hundreds_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		invalid_s2  <= invalid_s1;
		last_s2     <= last_s1;
		sec_s2      <= sec_s1;
		byte_s2     <= byte_s1;
		map_lane_s2 <= map_lane_s1;
		take_s2     <= take;
		ver_tens_s2 <= ver_tens_s1;
		hundreds_s2 <= tens_recip[RECIP_SHIFT +: 4];
	end

	// Stage 3 logic: the track bitmap, the version digit and the final byte
	// selection.
	logic [15:0] free_map;
	logic [15:0] trk_bitmap;
	logic [6:0]  digit;
	logic [7:0]  toc_c;
	logic [7:0]  data_c;

	always_comb begin
		free_map   = spt13 ? FREE_MAP_13 : FREE_MAP_16;
		trk_bitmap = free_map << take_s2;
		digit      = ver_tens_s2 - 7'(hundreds_s2 * 4'd10);

		if ((byte_s2 >= MAP_START) && (byte_s2 < MAP_END)) begin
			case (map_lane_s2)
				2'd0:    toc_c = trk_bitmap[15:8];
				2'd1:    toc_c = trk_bitmap[7:0];
				default: toc_c = 8'h00;
			endcase
		end else begin
			case (byte_s2)
				TOC_LINK_TRACK:  toc_c = {2'b00, cat_trk_q};
				TOC_LINK_SECTOR: toc_c = {3'b000, spt - 5'd1};
				TOC_VERSION:     toc_c = {1'b0, digit};
				TOC_VOLUME:      toc_c = volume_q;
				TOC_TS_CAPACITY: toc_c = TS_CAPACITY;
				TOC_LAST_TRACK:  toc_c = {2'b00, cat_trk_q};
				TOC_DIRECTION:   toc_c = 8'd1;
				TOC_TRACKS:      toc_c = TRACK_COUNT;
				TOC_SECTORS:     toc_c = {3'b000, spt};
				TOC_BYTES_LO:    toc_c = 8'h00;
				TOC_BYTES_HI:    toc_c = 8'h01;
				default:         toc_c = 8'h00;
			endcase
		end

		// Sectors past the table of contents hold only a link to the previous one;
		// sector 1 has an empty link.
		if (invalid_s2) begin
			data_c = 8'h00;
		end else if (sec_s2 == 4'd0) begin
			data_c = toc_c;
		end else if (byte_s2 == TOC_LINK_TRACK) begin
			data_c = (sec_s2 != 4'd1) ? {2'b00, cat_trk_q} : 8'h00;
		end else if (byte_s2 == TOC_LINK_SECTOR) begin
			data_c = {4'h0, sec_s2 - 4'd1};
		end else begin
			data_c = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		data_byte      <= data_c;
		offset_invalid <= invalid_s2;
		last_byte      <= last_s2 && !invalid_s2;
	end

	// An invalid offset gives a zero byte and never marks the end of the image.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && offset_invalid |-> (data_byte == 8'h00) && !last_byte)
		else $error("invalid offset produced data or an end mark");

	// Every result comes from a command transfer through the pipeline registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3) && !$past(busy, 3))
		else $error("result without a matching command");

	// Only a 13 sector image has offsets beyond its end.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && offset_invalid |-> spt13)
		else $error("offset flagged invalid in a 16 sector image");

	// The final byte of the image is the zero tail of the last catalog sector.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && last_byte |-> (data_byte == 8'h00))
		else $error("final image byte is not zero");

endmodule

`default_nettype wire
